FILE: rtl/core/usb_config_descriptor_scanner_defines.svh
// assertion macros for the usb configuration descriptor scanner
// no dependencies; included by the top level only
`ifndef USB_CONFIG_DESCRIPTOR_SCANNER_DEFINES_SVH
`define USB_CONFIG_DESCRIPTOR_SCANNER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UCDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucds assertion failed");

// next-cycle implication, disabled during reset
`define UCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucds assertion failed");

`endif

FILE: rtl/core/ucds_pkg.sv
// shared types and constants for the usb configuration descriptor scanner
// no dependencies
package ucds_pkg;

    localparam int MAX_BYTES = 512;
    localparam int CNT_W     = $clog2(MAX_BYTES + 2);

    // configuration register indexes
    localparam logic [1:0] REG_CLASS    = 2'd0;
    localparam logic [1:0] REG_SUBCLASS = 2'd1;
    localparam logic [1:0] REG_PROTOCOL = 2'd2;

    // descriptor codes
    localparam logic [7:0] DT_INTERFACE  = 8'd4;
    localparam logic [7:0] DT_ENDPOINT   = 8'd5;
    localparam logic [7:0] IF_MIN_LEN    = 8'd9;
    localparam logic [7:0] EP_MIN_LEN    = 8'd7;
    localparam logic [7:0] DESC_MIN_LEN  = 8'd2;
    localparam logic [1:0] XFER_BULK     = 2'd2;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_NONE      = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] class_code;
        logic [7:0] subclass_code;
        logic [7:0] protocol_code;
    } cfg_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] if_num;
        logic [7:0] in_addr;
        logic [7:0] out_addr;
    } result_t;

endpackage

FILE: rtl/core/usb_config_descriptor_scanner.sv
// a byte taken into the input register is parsed from there into the parse state, and a
// last byte also loads the result register. throughput: one byte per cycle while no last byte
// waits on out_stall, set by the parse update between the input register and the parse state / result register.
// a result waiting on out_stall holds only a last byte in the input register.
// reset (rst_n low, async): parse state cleared, match registers back to 8/6/80.
// depends on ucds_pkg, ucds_parse and usb_config_descriptor_scanner_defines.svh
`include "usb_config_descriptor_scanner_defines.svh"

module usb_config_descriptor_scanner (
    input  logic       clk,
    input  logic       rst_n,
    // configuration writes
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // descriptor bytes in
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    // scan result out
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] iface_number,
    output logic [7:0] in_endpoint_address,
    output logic [7:0] out_endpoint_address
);
    import ucds_pkg::*;

    cfg_t       cfg_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // result register
    logic       out_valid_reg;
    result_t    out_reg;

    result_t    parse_result;
    logic       out_free;
    logic       s1_go;
    logic       in_take;

    // match code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.class_code    <= 8'd8;
            cfg_reg.subclass_code <= 8'd6;
            cfg_reg.protocol_code <= 8'd80;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLASS:    cfg_reg.class_code    <= cfg_data;
                REG_SUBCLASS: cfg_reg.subclass_code <= cfg_data;
                REG_PROTOCOL: cfg_reg.protocol_code <= cfg_data;
                default: ;
            endcase
        end
    end

    // a non-last byte never needs the result slot, so only a last byte can wait
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    ucds_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (s1_go),
        .step_byte (s1_byte_reg),
        .step_last (s1_last_reg),
        .cfg       (cfg_reg),
        .result    (parse_result)
    );

    // result transfer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
            out_reg <= parse_result;
    end

    assign out_valid            = out_valid_reg;
    assign status               = out_reg.status;
    assign iface_number         = out_reg.if_num;
    assign in_endpoint_address  = out_reg.in_addr;
    assign out_endpoint_address = out_reg.out_addr;

    // a last byte that gets parsed always produces a result
    `UCDS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_go && s1_last_reg, out_valid_reg)
    // the input side only waits on a pending last byte behind a stalled result
    `UCDS_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && s1_last_reg && out_valid_reg && out_stall)
    // a found result carries one bulk-in and one bulk-out address
    `UCDS_ASSERT_NOW(a_found_addrs, clk, rst_n, out_valid_reg && out_reg.status == ST_FOUND, out_reg.in_addr[7] && !out_reg.out_addr[7] && out_reg.out_addr != 8'd0)
    // any other status reports zero fields
    `UCDS_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid_reg && out_reg.status != ST_FOUND, out_reg.if_num == 8'd0 && out_reg.in_addr == 8'd0 && out_reg.out_addr == 8'd0)

endmodule

FILE: rtl/core/ucds_parse.sv
// descriptor walker: running parse state and the result of a finished descriptor
// depends on ucds_pkg
module ucds_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        step_byte,
    input  logic              step_last,
    input  ucds_pkg::cfg_t    cfg,
    output ucds_pkg::result_t result
);
    import ucds_pkg::*;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_IF    = 2'd1,
        KIND_EP    = 2'd2
    } kind_t;

    logic [CNT_W-1:0] total_reg, total_next;
    logic [7:0]       pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       held_reg, held_next;
    logic [1:0]       cls_reg, cls_next;
    logic             inside_reg, inside_next;
    logic             seen_reg, seen_next;
    logic [7:0]       ifnum_reg, ifnum_next;
    logic [7:0]       in_reg, in_next;
    logic [7:0]       out_reg, out_next;
    logic [1:0]       err_reg, err_next;

    always_comb
    begin
        total_next  = total_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        kind_next   = kind_reg;
        held_next   = held_reg;
        cls_next    = cls_reg;
        inside_next = inside_reg;
        seen_next   = seen_reg;
        ifnum_next  = ifnum_reg;
        in_next     = in_reg;
        out_next    = out_reg;
        err_next    = err_reg;

        // saturating byte count, too long past the limit
        if (total_reg >= CNT_W'(MAX_BYTES))
        begin
            err_next[1] = 1'b1;
            total_next  = CNT_W'(MAX_BYTES + 1);
        end
        else
        begin
            total_next = total_reg + CNT_W'(1);
        end

        if (err_next == 2'b00)
        begin
            if (pos_reg == 8'd0)
            begin
                // length byte; a lone leftover byte is dropped
                if (!step_last)
                begin
                    len_next = step_byte;
                    pos_next = 8'd1;
                end
            end
            else if (pos_reg == 8'd1 && len_reg < DESC_MIN_LEN)
            begin
                err_next[0] = 1'b1;
            end
            else
            begin
                if (pos_reg == 8'd1)
                begin
                    kind_next = KIND_OTHER;
                    if (step_byte == DT_INTERFACE && len_reg >= IF_MIN_LEN)
                        kind_next = KIND_IF;
                    else if (step_byte == DT_ENDPOINT && len_reg >= EP_MIN_LEN)
                        kind_next = KIND_EP;
                    cls_next = 2'd0;
                end
                else if (kind_reg == KIND_IF)
                begin
                    unique case (pos_reg)
                        8'd2: held_next = step_byte;
                        8'd5: cls_next = (step_byte == cfg.class_code) ? 2'd1 : 2'd0;
                        8'd6: cls_next = (cls_reg == 2'd1 && step_byte == cfg.subclass_code)
                                         ? 2'd2 : 2'd0;
                        8'd7:
                        begin
                            cls_next = (cls_reg == 2'd2 && step_byte == cfg.protocol_code)
                                       ? 2'd3 : 2'd0;
                            inside_next = (cls_next == 2'd3);
                            if (inside_next)
                            begin
                                seen_next  = 1'b1;
                                ifnum_next = held_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                else if (kind_reg == KIND_EP)
                begin
                    if (pos_reg == 8'd2)
                        held_next = step_byte;
                    else if (pos_reg == 8'd3 && inside_reg && step_byte[1:0] == XFER_BULK)
                    begin
                        if (held_reg[7])
                            in_next = held_reg;
                        else
                            out_next = held_reg;
                    end
                end

                // end of sub-descriptor, or truncated by the last byte
                if ({1'b0, pos_reg} + 9'd1 >= {1'b0, len_reg})
                begin
                    pos_next = 8'd0;
                end
                else
                begin
                    if (step_last)
                        err_next[0] = 1'b1;
                    pos_next = pos_reg + 8'd1;
                end
            end
        end

        // result of the finished descriptor
        result.if_num   = 8'd0;
        result.in_addr  = 8'd0;
        result.out_addr = 8'd0;
        if (err_next[1])
            result.status = ST_TOO_LONG;
        else if (err_next[0])
            result.status = ST_MALFORMED;
        else if (seen_next && in_next != 8'd0 && out_next != 8'd0)
        begin
            result.status   = ST_FOUND;
            result.if_num   = ifnum_next;
            result.in_addr  = in_next;
            result.out_addr = out_next;
        end
        else
            result.status = ST_NONE;

        // start over after the last byte
        if (step_last)
        begin
            total_next  = '0;
            pos_next    = 8'd0;
            len_next    = 8'd0;
            kind_next   = KIND_OTHER;
            held_next   = 8'd0;
            cls_next    = 2'd0;
            inside_next = 1'b0;
            seen_next   = 1'b0;
            ifnum_next  = 8'd0;
            in_next     = 8'd0;
            out_next    = 8'd0;
            err_next    = 2'b00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            pos_reg    <= 8'd0;
            len_reg    <= 8'd0;
            kind_reg   <= KIND_OTHER;
            held_reg   <= 8'd0;
            cls_reg    <= 2'd0;
            inside_reg <= 1'b0;
            seen_reg   <= 1'b0;
            ifnum_reg  <= 8'd0;
            in_reg     <= 8'd0;
            out_reg    <= 8'd0;
            err_reg    <= 2'b00;
        end
        else if (step_en)
        begin
            total_reg  <= total_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            kind_reg   <= kind_next;
            held_reg   <= held_next;
            cls_reg    <= cls_next;
            inside_reg <= inside_next;
            seen_reg   <= seen_next;
            ifnum_reg  <= ifnum_next;
            in_reg     <= in_next;
            out_reg    <= out_next;
            err_reg    <= err_next;
        end
    end

endmodule

FILE: bench/scan_checker.sv
// scoreboard for the usb configuration descriptor scanner: follows the config port,
// tracks every byte transfer, predicts each scan result and checks result transfers
// depends on ucds_pkg
module scan_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] status,
    input  logic [7:0] iface_number,
    input  logic [7:0] in_endpoint_address,
    input  logic [7:0] out_endpoint_address,
    output int         fail_count,
    output int         pending_scans
);
    import ucds_pkg::*;

    // byte offsets inside a sub-descriptor
    localparam logic [7:0] OFS_TYPE     = 8'd1;
    localparam logic [7:0] OFS_NUMBER   = 8'd2;
    localparam logic [7:0] OFS_ATTR     = 8'd3;
    localparam logic [7:0] OFS_CLASS    = 8'd5;
    localparam logic [7:0] OFS_SUBCLASS = 8'd6;
    localparam logic [7:0] OFS_PROTOCOL = 8'd7;

    cfg_t       match_cfg;
    result_t    expected_scans[$];
    result_t    want;

    int         byte_count;
    logic [7:0] offset;
    logic [7:0] sub_len;
    logic [7:0] sub_kind;
    logic [7:0] held;
    logic [1:0] match_depth;
    logic       in_storage;
    logic       storage_found;
    logic [7:0] storage_num;
    logic [7:0] ep_in_addr;
    logic [7:0] ep_out_addr;
    logic [1:0] err;        // bit 0 malformed, bit 1 too long

    task automatic clear_scan_state();
        byte_count    = 0;
        offset        = 8'd0;
        sub_len       = 8'd0;
        sub_kind      = 8'd0;
        held          = 8'd0;
        match_depth   = 2'd0;
        in_storage    = 1'b0;
        storage_found = 1'b0;
        storage_num   = 8'd0;
        ep_in_addr    = 8'd0;
        ep_out_addr   = 8'd0;
        err           = 2'b00;
    endtask

    // advance the scan by one byte, queue a result on the last one
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        result_t r;
        status_t verdict;
        if (byte_count >= MAX_BYTES) begin
            err[1]     = 1'b1;
            byte_count = MAX_BYTES + 1;
        end else begin
            byte_count++;
        end

        if (err == 2'b00) begin
            if (offset == 8'd0) begin
                // a lone length byte at the end is dropped
                if (!fin) begin
                    sub_len = b;
                    offset  = OFS_TYPE;
                end
            end else if (offset == OFS_TYPE && sub_len < DESC_MIN_LEN) begin
                err[0] = 1'b1;
            end else begin
                if (offset == OFS_TYPE) begin
                    sub_kind = 8'd0;
                    if (b == DT_INTERFACE && sub_len >= IF_MIN_LEN)
                        sub_kind = DT_INTERFACE;
                    else if (b == DT_ENDPOINT && sub_len >= EP_MIN_LEN)
                        sub_kind = DT_ENDPOINT;
                    match_depth = 2'd0;
                end else if (sub_kind == DT_INTERFACE) begin
                    if (offset == OFS_NUMBER) begin
                        held = b;
                    end else if (offset == OFS_CLASS) begin
                        match_depth = (b == match_cfg.class_code) ? 2'd1 : 2'd0;
                    end else if (offset == OFS_SUBCLASS) begin
                        match_depth = (match_depth == 2'd1 && b == match_cfg.subclass_code)
                                      ? 2'd2 : 2'd0;
                    end else if (offset == OFS_PROTOCOL) begin
                        match_depth = (match_depth == 2'd2 && b == match_cfg.protocol_code)
                                      ? 2'd3 : 2'd0;
                        in_storage = (match_depth == 2'd3);
                        if (in_storage) begin
                            storage_found = 1'b1;
                            storage_num   = held;
                        end
                    end
                end else if (sub_kind == DT_ENDPOINT) begin
                    if (offset == OFS_NUMBER) begin
                        held = b;
                    end else if (offset == OFS_ATTR && in_storage && b[1:0] == XFER_BULK) begin
                        if (held[7])
                            ep_in_addr = held;
                        else
                            ep_out_addr = held;
                    end
                end

                if (int'(offset) + 1 >= int'(sub_len)) begin
                    offset = 8'd0;
                end else begin
                    if (fin)
                        err[0] = 1'b1;
                    offset = offset + 8'd1;
                end
            end
        end

        if (fin) begin
            if (err[1])
                verdict = ST_TOO_LONG;
            else if (err[0])
                verdict = ST_MALFORMED;
            else if (storage_found && ep_in_addr != 8'd0 && ep_out_addr != 8'd0)
                verdict = ST_FOUND;
            else
                verdict = ST_NONE;
            r.status   = verdict;
            r.if_num   = (verdict == ST_FOUND) ? storage_num : 8'd0;
            r.in_addr  = (verdict == ST_FOUND) ? ep_in_addr : 8'd0;
            r.out_addr = (verdict == ST_FOUND) ? ep_out_addr : 8'd0;
            expected_scans.push_back(r);
            clear_scan_state();
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            match_cfg = '{class_code: 8'd8, subclass_code: 8'd6, protocol_code: 8'd80};
            clear_scan_state();
            expected_scans.delete();
            fail_count = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_scans.size() == 0) begin
                    $error("result transfer with no descriptor outstanding");
                    fail_count++;
                end else begin
                    want = expected_scans.pop_front();
                    compare_field("status", {6'd0, want.status}, {6'd0, status});
                    compare_field("iface_number", want.if_num, iface_number);
                    compare_field("in_endpoint_address", want.in_addr, in_endpoint_address);
                    compare_field("out_endpoint_address", want.out_addr, out_endpoint_address);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_CLASS:    match_cfg.class_code    = cfg_data;
                    REG_SUBCLASS: match_cfg.subclass_code = cfg_data;
                    REG_PROTOCOL: match_cfg.protocol_code = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                parse_byte(data_byte, last_byte);
        end
        pending_scans = expected_scans.size();
    end

endmodule

FILE: bench/testbench.sv
// top of the descriptor scanner bench: clock, reset, descriptor generation and verdict
// depends on ucds_pkg, usb_config_descriptor_scanner and scan_checker
module testbench;
    import ucds_pkg::*;

    // generous bound: ~1100 byte transfers, sender idle 78% of cycles, receiver
    // stalling 78% on a few dozen results, still well under this
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASE_SCANS   = 3;
    localparam int SETTLE_CYCLES = 4;

    // endpoint direction asked of the generator
    localparam int EP_ANY = 0;
    localparam int EP_IN  = 1;
    localparam int EP_OUT = 2;

    localparam logic [7:0] DT_CONFIGURATION = 8'd2;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic [7:0] iface_number;
    logic [7:0] in_endpoint_address;
    logic [7:0] out_endpoint_address;

    int         fail_count;
    int         pending_scans;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         items_sent = 0;
    int         scans_sent = 0;
    int         cycle_count = 0;

    // match values as last written, so the generator can aim at them
    cfg_t       match_now;
    logic [7:0] scan_bytes[$];

    usb_config_descriptor_scanner dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .data_byte            (data_byte),
        .last_byte            (last_byte),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .status               (status),
        .iface_number         (iface_number),
        .in_endpoint_address  (in_endpoint_address),
        .out_endpoint_address (out_endpoint_address)
    );

    scan_checker scan_check (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .data_byte            (data_byte),
        .last_byte            (last_byte),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .status               (status),
        .iface_number         (iface_number),
        .in_endpoint_address  (in_endpoint_address),
        .out_endpoint_address (out_endpoint_address),
        .fail_count           (fail_count),
        .pending_scans        (pending_scans)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // generic sub-descriptor: length, type, random body
    function automatic void add_filler(input logic [7:0] len, input logic [7:0] kind);
        scan_bytes.push_back(len);
        scan_bytes.push_back(kind);
        for (int i = 2; i < len; i++)
            scan_bytes.push_back(8'($urandom));
    endfunction

    // interface descriptor, either hitting the match values or missing in one spot or in all three codes
    function automatic void add_interface(input bit matching);
        logic [7:0] len;
        logic [7:0] cls;
        logic [7:0] sub;
        logic [7:0] prt;
        len = ($urandom_range(4) == 0) ? 8'($urandom_range(10, 12)) : IF_MIN_LEN;
        cls = match_now.class_code;
        sub = match_now.subclass_code;
        prt = match_now.protocol_code;
        if (!matching)
        begin
            // a single wrong code shows whether the match chain breaks at the right byte
            case ($urandom_range(3))
                0: cls = cls ^ 8'($urandom_range(1, 255));
                1: sub = sub ^ 8'($urandom_range(1, 255));
                2: prt = prt ^ 8'($urandom_range(1, 255));
                default:
                begin
                    cls = 8'($urandom);
                    sub = 8'($urandom);
                    prt = 8'($urandom);
                end
            endcase
        end
        scan_bytes.push_back(len);
        scan_bytes.push_back(DT_INTERFACE);
        scan_bytes.push_back(8'($urandom));     // interface number
        scan_bytes.push_back(8'($urandom));     // alternate setting
        scan_bytes.push_back(8'($urandom));     // endpoint count
        scan_bytes.push_back(cls);
        scan_bytes.push_back(sub);
        scan_bytes.push_back(prt);
        scan_bytes.push_back(8'($urandom));     // string index
        for (int i = IF_MIN_LEN; i < len; i++)
            scan_bytes.push_back(8'($urandom));
    endfunction

    // endpoint descriptor; a requested direction also forces bulk attributes
    function automatic void add_endpoint(input int dir);
        logic [7:0] len;
        logic [7:0] addr;
        logic [7:0] attr;
        len  = ($urandom_range(4) == 0) ? 8'($urandom_range(8, 10)) : EP_MIN_LEN;
        addr = 8'($urandom);
        if (dir == EP_IN)
            addr[7] = 1'b1;
        else if (dir == EP_OUT)
            addr[7] = 1'b0;
        // address zero reads as no endpoint at all
        if ($urandom_range(9) == 0)
            addr = 8'd0;
        attr = 8'($urandom);
        if (dir != EP_ANY || $urandom_range(1) != 0)
            attr[1:0] = XFER_BULK;
        scan_bytes.push_back(len);
        scan_bytes.push_back(DT_ENDPOINT);
        scan_bytes.push_back(addr);
        scan_bytes.push_back(attr);
        for (int i = 4; i < len; i++)
            scan_bytes.push_back(8'($urandom));
    endfunction

    // loose mix of well-formed sub-descriptors
    function automatic void add_mixed(input int count);
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(4))
                0:       add_interface($urandom_range(1) != 0);
                1, 2:    add_endpoint(EP_ANY);
                3:       add_filler(8'($urandom_range(2, 12)), 8'($urandom));
                // interface or endpoint type code, but too short to qualify
                default: add_filler(8'($urandom_range(2, 6)),
                                    ($urandom_range(1) != 0) ? DT_INTERFACE : DT_ENDPOINT);
            endcase
        end
    endfunction

    // what a real storage device reports, with some variation
    function automatic void add_storage();
        add_filler(IF_MIN_LEN, DT_CONFIGURATION);
        if ($urandom_range(3) == 0)
            add_mixed(1);
        add_interface($urandom_range(4) != 0);
        case ($urandom_range(3))
            0:
            begin
                add_endpoint(EP_IN);
                add_endpoint(EP_OUT);
            end
            1:
            begin
                add_endpoint(EP_OUT);
                add_endpoint(EP_IN);
            end
            2: add_endpoint(EP_ANY);
            default:
            begin
                // endpoints behind a second interface only count if it matches too
                add_interface($urandom_range(1) != 0);
                add_endpoint(EP_IN);
                add_endpoint(EP_OUT);
            end
        endcase
        if ($urandom_range(2) == 0)
            add_mixed($urandom_range(1, 3));
    endfunction

    // hold the sender until every outstanding scan result has been transferred
    task automatic drain_scans();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_scans != 0)
            @(negedge clk);
    endtask

    // push the queued descriptor out byte by byte, last marker on the final byte
    task automatic send_scan();
        for (int i = 0; i < scan_bytes.size(); i++)
        begin
            while ($urandom_range(99) < gap_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= scan_bytes[i];
            last_byte <= (i == scan_bytes.size() - 1);
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
            items_sent++;
        end
        scan_bytes.delete();
        scans_sent++;
        // now and then let everything drain before the next descriptor
        if ($urandom_range(15) == 0)
            drain_scans();
    endtask

    // new match codes and idling mix; only written with the scanner idle
    task automatic retune(input logic [7:0] cls, input logic [7:0] sub, input logic [7:0] prt,
                          input int gap, input int stall);
        drain_scans();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CLASS;
        cfg_data  <= cls;
        @(negedge clk);
        cfg_index <= REG_SUBCLASS;
        cfg_data  <= sub;
        @(negedge clk);
        cfg_index <= REG_PROTOCOL;
        cfg_data  <= prt;
        @(negedge clk);
        cfg_we    <= 1'b0;
        match_now = '{class_code: cls, subclass_code: sub, protocol_code: prt};
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    // random descriptors: mostly storage-like, the rest mixed, junk or broken
    task automatic run_phase();
        int start_items;
        int start_scans;
        int pick;
        int cut;
        start_items = items_sent;
        start_scans = scans_sent;
        while (items_sent - start_items < PHASE_ITEMS || scans_sent - start_scans < PHASE_SCANS)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                add_storage();
            end
            else if (pick < 72)
            begin
                add_mixed($urandom_range(1, 6));
            end
            else if (pick < 80)
            begin
                // raw noise
                repeat ($urandom_range(1, 16)) scan_bytes.push_back(8'($urandom));
            end
            else if (pick < 88)
            begin
                // cut off somewhere, usually inside a sub-descriptor
                add_storage();
                cut = $urandom_range(1, scan_bytes.size() - 1);
                while (scan_bytes.size() > cut)
                    void'(scan_bytes.pop_back());
            end
            else if (pick < 94)
            begin
                // length byte of zero or one somewhere in the stream
                add_mixed($urandom_range(0, 2));
                scan_bytes.push_back(8'($urandom_range(1)));
                scan_bytes.push_back(8'($urandom));
                add_mixed($urandom_range(0, 2));
            end
            else
            begin
                // stray byte after the last complete sub-descriptor
                add_storage();
                scan_bytes.push_back(8'($urandom));
            end
            send_scan();
        end
    endtask

    initial
    begin
        int overlong_len;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_CLASS;
        cfg_data  = 8'd0;
        in_valid  = 1'b0;
        data_byte = 8'd0;
        last_byte = 1'b0;
        match_now = '{class_code: 8'd8, subclass_code: 8'd6, protocol_code: 8'd80};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: lone leftover byte, zero and one length bytes, a cut-off
        // interface, then a storage interface whose bulk-out endpoint sits at 0
        scan_bytes = {8'h42};
        send_scan();
        scan_bytes = {8'd0, DT_INTERFACE};
        send_scan();
        scan_bytes = {8'd1, 8'hff};
        send_scan();
        scan_bytes = {IF_MIN_LEN, DT_INTERFACE, 8'd3};
        send_scan();
        scan_bytes = {IF_MIN_LEN, DT_INTERFACE, 8'd2, 8'd0, 8'd1,
                      match_now.class_code, match_now.subclass_code,
                      match_now.protocol_code, 8'd0,
                      EP_MIN_LEN, DT_ENDPOINT, 8'd0, {6'd0, XFER_BULK}, 8'd64, 8'd0, 8'd0};
        send_scan();

        // reset match values, no idling
        run_phase();

        // all-zero codes, sender mostly idle
        retune(8'd0, 8'd0, 8'd0, 78, 0);
        run_phase();

        // all-ones codes, receiver mostly stalling; one descriptor just past the limit
        retune(8'hff, 8'hff, 8'hff, 0, 78);
        overlong_len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
        while (scan_bytes.size() < overlong_len)
            add_storage();
        while (scan_bytes.size() > overlong_len)
            void'(scan_bytes.pop_back());
        send_scan();
        run_phase();

        // random codes, light idling on both sides
        retune(8'($urandom), 8'($urandom), 8'($urandom), 15, 15);
        run_phase();

        // back to mass storage codes, full rate
        retune(8'd8, 8'd6, 8'd80, 0, 0);
        run_phase();

        drain_scans();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
